FILE: rtl/core/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg: shared definitions for the mean and standard deviation accumulator
// Widths of the running sums, the divider and root units, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package msa_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int COUNT_RESET     = 2;

	localparam int OUT_BITS   = 16;
	localparam int SUM_W      = 32;
	localparam int SQSUM_W    = 48;
	localparam int DIVIDEND_W = 64;
	localparam int ROOT_IN_W  = SQSUM_W;
	localparam int ROOT_OUT_W = ROOT_IN_W / 2;

	typedef enum logic [1:0] {
		OP_MEAN,
		OP_SQ,
		OP_VAR
	} div_op_t;

	typedef struct packed {
		logic    accum;
		logic    clear_sums;
		logic    cfg_we;
		logic    stream;
		logic    stat_clear;
		logic    div_start;
		div_op_t div_op;
		logic    mean_cap;
		logic    sq_load;
		logic    diff_cap;
		logic    root_start;
		logic    dev_cap;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic root_done;
		logic cnt_zero;
		logic cnt_small;
	} status_t;

endpackage

FILE: rtl/core/mean_stddev_accumulator_top.sv
// ----------------------------------------------------------------------------
// mean_stddev_accumulator_top: running mean and sample standard deviation
// Two Q8.8 sample streams are summed and squared-summed; a beat marked last
// produces the mean and sample standard deviation of each stream.
// ----------------------------------------------------------------------------
// Sample beats that are not marked last are taken one per cycle. A beat
// marked last closes the input while the batch statistics are formed:
// each stream runs three passes through a shared 64-step bit-serial divider
// and a 24-step root unit before the result is loaded and the input opens
// again (fewer passes when the count is below two). Samples of the next
// batch are taken while a finished result still waits on the output; only
// the next batch end then waits for the output to drain. The sample count
// register may be written at any time the block is idle and takes effect
// for the next batch end.
module mean_stddev_accumulator_top #(
	parameter int SAMPLE_BITS = msa_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = msa_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [COUNT_BITS-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        fault_sample,
	input  logic [SAMPLE_BITS-1:0]        dist_sample,
	input  logic                          batch_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [msa_pkg::OUT_BITS-1:0]  fault_mean,
	output logic [msa_pkg::OUT_BITS-1:0]  fault_stddev,
	output logic [msa_pkg::OUT_BITS-1:0]  dist_mean,
	output logic [msa_pkg::OUT_BITS-1:0]  dist_stddev,
	output logic                          count_too_small
);

	msa_pkg::cmd_t    cmd;
	msa_pkg::status_t status;

	msa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.batch_last (batch_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.status     (status),
		.cmd        (cmd)
	);

	msa_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_data        (cfg_data),
		.fault_sample    (fault_sample),
		.dist_sample     (dist_sample),
		.fault_mean      (fault_mean),
		.fault_stddev    (fault_stddev),
		.dist_mean       (dist_mean),
		.dist_stddev     (dist_stddev),
		.count_too_small (count_too_small)
	);

endmodule

FILE: rtl/core/msa_div.sv
// ----------------------------------------------------------------------------
// msa_div: iterative restoring divider
// Divides a 64-bit dividend by an unsigned divisor, one quotient bit per
// cycle. The quotient is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module msa_div #(
	parameter int DIVISOR_W = msa_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [msa_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]            divisor,
	output logic [msa_pkg::DIVIDEND_W-1:0]  quotient,
	output logic                            done
);

	localparam int DW    = msa_pkg::DIVIDEND_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] den_q;
	logic [DW-1:0]        quo_q;

	logic [DIVISOR_W:0] shifted;
	logic               fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIVISOR_W'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[DIVISOR_W-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

FILE: rtl/core/msa_root.sv
// ----------------------------------------------------------------------------
// msa_root: iterative integer floor square root
// Digit-by-digit root of a 48-bit value, one result bit per cycle.
// The result is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module msa_root (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [msa_pkg::ROOT_IN_W-1:0]   operand,
	output logic [msa_pkg::ROOT_OUT_W-1:0]  root,
	output logic                            done
);

	localparam int W = msa_pkg::ROOT_IN_W;

	logic         busy_q;
	logic         done_q;
	logic [W-1:0] val_q;
	logic [W-1:0] res_q;
	logic [W-1:0] bit_q;

	logic [W:0] trial;
	logic       take;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = ({1'b0, val_q} >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= operand;
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (take) begin
				val_q <= W'({1'b0, val_q} - trial);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[msa_pkg::ROOT_OUT_W-1:0];
	assign done = done_q;

endmodule

FILE: rtl/core/msa_datapath.sv
// ----------------------------------------------------------------------------
// msa_datapath: accumulators and batch-end arithmetic
// Holds the running sums, the sample count register, the shared divider and
// root units, per-stream statistics and the output payload register.
// ----------------------------------------------------------------------------
module msa_datapath #(
	parameter int SAMPLE_BITS = msa_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = msa_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msa_pkg::cmd_t                 cmd,
	output msa_pkg::status_t              status,
	input  logic [COUNT_BITS-1:0]         cfg_data,
	input  logic [SAMPLE_BITS-1:0]        fault_sample,
	input  logic [SAMPLE_BITS-1:0]        dist_sample,
	output logic [msa_pkg::OUT_BITS-1:0]  fault_mean,
	output logic [msa_pkg::OUT_BITS-1:0]  fault_stddev,
	output logic [msa_pkg::OUT_BITS-1:0]  dist_mean,
	output logic [msa_pkg::OUT_BITS-1:0]  dist_stddev,
	output logic                          count_too_small
);

	localparam int DW  = msa_pkg::DIVIDEND_W;
	localparam int SW  = msa_pkg::SUM_W;
	localparam int QW  = msa_pkg::SQSUM_W;
	localparam int OW  = msa_pkg::OUT_BITS;
	localparam logic [DW-1:0] SAMPLE_MAX = (DW'(1) << SAMPLE_BITS) - DW'(1);

	function automatic logic [OW-1:0] sat_out(input logic [DW-1:0] v);
		return (v > SAMPLE_MAX) ? SAMPLE_MAX[OW-1:0] : v[OW-1:0];
	endfunction

	logic [COUNT_BITS-1:0] count_q;
	logic [SW-1:0]         fault_sum_q;
	logic [SW-1:0]         dist_sum_q;
	logic [QW-1:0]         fault_sqsum_q;
	logic [QW-1:0]         dist_sqsum_q;
	logic [DW-1:0]         sq_q;
	logic [QW-1:0]         diff_q;
	logic [OW-1:0]         mean_q [2];
	logic [OW-1:0]         dev_q  [2];

	logic [2*SAMPLE_BITS-1:0] fault_sq;
	logic [2*SAMPLE_BITS-1:0] dist_sq;
	logic [SW-1:0]            sum_sel;
	logic [QW-1:0]            sqsum_sel;
	logic [DW-1:0]            sqsum_ext;
	logic [DW-1:0]            div_dividend;
	logic [COUNT_BITS-1:0]    div_divisor;
	logic [DW-1:0]            div_quo;
	logic                     div_done;
	logic [msa_pkg::ROOT_OUT_W-1:0] root_res;
	logic                     root_done;

	assign fault_sq  = fault_sample * fault_sample;
	assign dist_sq   = dist_sample * dist_sample;
	assign sum_sel   = cmd.stream ? dist_sum_q : fault_sum_q;
	assign sqsum_sel = cmd.stream ? dist_sqsum_q : fault_sqsum_q;
	assign sqsum_ext = DW'(sqsum_sel);

	always_comb begin
		unique case (cmd.div_op)
			msa_pkg::OP_MEAN: begin
				div_dividend = DW'(sum_sel);
				div_divisor  = count_q;
			end
			msa_pkg::OP_SQ: begin
				div_dividend = sq_q;
				div_divisor  = count_q;
			end
			msa_pkg::OP_VAR: begin
				div_dividend = DW'(diff_q);
				div_divisor  = count_q - COUNT_BITS'(1);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = count_q;
			end
		endcase
	end

	msa_div #(
		.DIVISOR_W (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

	msa_root u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.root_start),
		.operand (div_quo[QW-1:0]),
		.root    (root_res),
		.done    (root_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= COUNT_BITS'(msa_pkg::COUNT_RESET);
			fault_sum_q   <= '0;
			dist_sum_q    <= '0;
			fault_sqsum_q <= '0;
			dist_sqsum_q  <= '0;
		end else begin
			if (cmd.cfg_we) begin
				count_q <= cfg_data;
			end
			if (cmd.clear_sums) begin
				fault_sum_q   <= '0;
				dist_sum_q    <= '0;
				fault_sqsum_q <= '0;
				dist_sqsum_q  <= '0;
			end else if (cmd.accum) begin
				fault_sum_q   <= fault_sum_q + SW'(fault_sample);
				dist_sum_q    <= dist_sum_q + SW'(dist_sample);
				fault_sqsum_q <= fault_sqsum_q + QW'(fault_sq);
				dist_sqsum_q  <= dist_sqsum_q + QW'(dist_sq);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			sq_q <= DW'(sum_sel) * DW'(sum_sel);
		end
		// A square of the sum over the count above the sum of squares leaves a
		// negative variance, which is clamped to zero.
		if (cmd.diff_cap) begin
			diff_q <= (sqsum_ext > div_quo) ? QW'(sqsum_ext - div_quo) : '0;
		end
		if (cmd.stat_clear) begin
			mean_q[cmd.stream] <= '0;
			dev_q[cmd.stream]  <= '0;
		end else begin
			if (cmd.mean_cap) begin
				mean_q[cmd.stream] <= sat_out(div_quo);
			end
			if (cmd.dev_cap) begin
				dev_q[cmd.stream] <= sat_out(DW'(root_res));
			end
		end
		if (cmd.out_load) begin
			fault_mean      <= mean_q[0];
			fault_stddev    <= dev_q[0];
			dist_mean       <= mean_q[1];
			dist_stddev     <= dev_q[1];
			count_too_small <= (count_q < COUNT_BITS'(2));
		end
	end

	assign status.div_done  = div_done;
	assign status.root_done = root_done;
	assign status.cnt_zero  = (count_q == '0);
	assign status.cnt_small = (count_q < COUNT_BITS'(2));

endmodule

FILE: rtl/core/msa_ctrl.sv
// ----------------------------------------------------------------------------
// msa_ctrl: sequencing controller
// Accepts samples, runs the batch-end sequence for each stream in turn and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module msa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              batch_last,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  msa_pkg::status_t  status,
	output msa_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_SQ,
		ST_SQDIV_GO,
		ST_SQDIV_WAIT,
		ST_VDIV_GO,
		ST_VDIV_WAIT,
		ST_ROOT_WAIT,
		ST_NEXT,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   strm_q;
	logic   out_valid_q;
	logic   out_free;
	logic   in_beat;

	assign in_ready  = (state_q == ST_ACCUM);
	assign in_beat   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		cmd            = '0;
		cmd.div_op     = msa_pkg::OP_MEAN;
		cmd.stream     = strm_q;
		cmd.cfg_we     = cfg_valid;
		cmd.accum      = in_beat;
		unique case (state_q)
			ST_ACCUM: begin
			end
			ST_MEAN_GO: begin
				cmd.stat_clear = 1'b1;
				cmd.div_start  = !status.cnt_zero;
			end
			ST_MEAN_WAIT: begin
				cmd.mean_cap = status.div_done;
			end
			ST_SQ: begin
				cmd.sq_load = 1'b1;
			end
			ST_SQDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = msa_pkg::OP_SQ;
			end
			ST_SQDIV_WAIT: begin
				cmd.diff_cap = status.div_done;
			end
			ST_VDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = msa_pkg::OP_VAR;
			end
			ST_VDIV_WAIT: begin
				cmd.root_start = status.div_done;
			end
			ST_ROOT_WAIT: begin
				cmd.dev_cap = status.root_done;
			end
			ST_NEXT: begin
			end
			ST_OUT: begin
				cmd.out_load   = out_free;
				cmd.clear_sums = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			strm_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_ACCUM: begin
					if (in_beat && batch_last) begin
						strm_q  <= 1'b0;
						state_q <= ST_MEAN_GO;
					end
				end
				ST_MEAN_GO: begin
					state_q <= status.cnt_zero ? ST_NEXT : ST_MEAN_WAIT;
				end
				ST_MEAN_WAIT: begin
					if (status.div_done) begin
						state_q <= status.cnt_small ? ST_NEXT : ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_SQDIV_GO;
				end
				ST_SQDIV_GO: begin
					state_q <= ST_SQDIV_WAIT;
				end
				ST_SQDIV_WAIT: begin
					if (status.div_done) begin
						state_q <= ST_VDIV_GO;
					end
				end
				ST_VDIV_GO: begin
					state_q <= ST_VDIV_WAIT;
				end
				ST_VDIV_WAIT: begin
					if (status.div_done) begin
						state_q <= ST_ROOT_WAIT;
					end
				end
				ST_ROOT_WAIT: begin
					if (status.root_done) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (strm_q) begin
						state_q <= ST_OUT;
					end else begin
						strm_q  <= 1'b1;
						state_q <= ST_MEAN_GO;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_ACCUM;
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/msa_checker.sv
// ----------------------------------------------------------------------------
// msa_checker: port-level checks for the accumulator
// Watches the top-level ports and flags sequencing and result errors.
// ----------------------------------------------------------------------------
module msa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          batch_last,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [msa_pkg::OUT_BITS-1:0]  fault_mean,
	input logic [msa_pkg::OUT_BITS-1:0]  fault_stddev,
	input logic [msa_pkg::OUT_BITS-1:0]  dist_mean,
	input logic [msa_pkg::OUT_BITS-1:0]  dist_stddev,
	input logic                          count_too_small
);

	// A waiting result must not change under the consumer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fault_mean)
			&& $stable(fault_stddev) && $stable(dist_mean)
			&& $stable(dist_stddev) && $stable(count_too_small))
		else $error("result changed while stalled");

	// A batch end closes the input for the statistics pass.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && batch_last |=> !in_ready)
		else $error("input stayed open after batch end");

	// A new result appears only at the end of a statistics pass.
	a_out_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a batch end");

	// With fewer than two samples the deviations are forced to zero.
	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count_too_small |-> fault_stddev == '0 && dist_stddev == '0)
		else $error("nonzero deviation with too small a count");

endmodule

bind mean_stddev_accumulator_top msa_checker u_msa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.batch_last      (batch_last),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.fault_mean      (fault_mean),
	.fault_stddev    (fault_stddev),
	.dist_mean       (dist_mean),
	.dist_stddev     (dist_stddev),
	.count_too_small (count_too_small)
);
